/* hdl/tvsa_pkg.sv */
// package for the typed vector-scalar alu
// types, operation codes and width masks shared by all modules
`timescale 1ns / 1ps
`default_nettype none
package tvsa_pkg;

  localparam int DATA_W = 64;
  localparam int DIV_STEPS = 64;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_ETYPE  = 2'd0,
    CFG_OP     = 2'd1,
    CFG_SCALAR = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic              last;
    logic              dz;
    logic              is_div;
    logic              neg;
    logic [2:0]        etype;
    logic [DATA_W-1:0] res;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] quo;
    logic [DATA_W-1:0] dvs;
  } tvsa_item_t;

  function automatic logic [DATA_W-1:0] width_mask(input logic [1:0] sz);
    logic [DATA_W-1:0] m;
    case (sz)
      2'd0:    m = 64'h0000_0000_0000_00ff;
      2'd1:    m = 64'h0000_0000_0000_ffff;
      2'd2:    m = 64'h0000_0000_ffff_ffff;
      default: m = 64'hffff_ffff_ffff_ffff;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

/* hdl/tvsa_front.sv */
// front end: operand masking, sign handling, add/sub and split multiply
// three register stages; depends on tvsa_pkg
`timescale 1ns / 1ps
`default_nettype none
module tvsa_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      in_v,
  input  wire logic [tvsa_pkg::DATA_W-1:0] elem,
  input  wire logic                      last_in,
  input  wire logic [2:0]                etype,
  input  wire logic [1:0]                op,
  input  wire logic [tvsa_pkg::DATA_W-1:0] scalar,
  output logic                           out_v,
  output tvsa_pkg::tvsa_item_t           out_item
);
  import tvsa_pkg::*;

  logic [DATA_W-1:0] m, a, b, sa, sb;
  logic a_neg, b_neg;

  // stage a
  logic va;
  logic last_a, dz_a, neg_a;
  logic [2:0] etype_a;
  logic [1:0] op_a;
  logic [DATA_W-1:0] a_a, b_a, mag_a_a, mag_b_a;

  // stage b
  logic vb;
  logic last_b, dz_b, neg_b;
  logic [2:0] etype_b;
  logic [1:0] op_b;
  logic [DATA_W-1:0] res_b, mag_a_b, mag_b_b, pp0;
  logic [31:0] pp1, pp2;
  logic [63:0] p1_full, p2_full;
  logic [DATA_W-1:0] addsub;

  always_comb begin
    m     = width_mask(etype[1:0]);
    a     = elem & m;
    b     = scalar & m;
    a_neg = !etype[2] && |(a & (m ^ (m >> 1)));
    b_neg = !etype[2] && |(b & (m ^ (m >> 1)));
    sa    = a_neg ? (a | ~m) : a;
    sb    = b_neg ? (b | ~m) : b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_v;
    end
    if (en) begin
      last_a  <= last_in;
      etype_a <= etype;
      op_a    <= op;
      a_a     <= a;
      b_a     <= b;
      dz_a    <= (op == OP_DIV) && (b == '0);
      neg_a   <= a_neg ^ b_neg;
      mag_a_a <= a_neg ? (~sa + 64'd1) : sa;
      mag_b_a <= b_neg ? (~sb + 64'd1) : sb;
    end
  end

  always_comb begin
    case (op_a)
      OP_ADD:  addsub = a_a + b_a;
      OP_SUB:  addsub = a_a - b_a;
      default: addsub = a_a;
    endcase
    p1_full = a_a[31:0] * b_a[63:32];
    p2_full = a_a[63:32] * b_a[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
    if (en) begin
      last_b  <= last_a;
      etype_b <= etype_a;
      op_b    <= op_a;
      dz_b    <= dz_a;
      neg_b   <= neg_a;
      res_b   <= addsub;
      mag_a_b <= mag_a_a;
      mag_b_b <= mag_b_a;
      pp0     <= a_a[31:0] * b_a[31:0];
      pp1     <= p1_full[31:0];
      pp2     <= p2_full[31:0];
    end
  end

  // stage c
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= vb;
    end
    if (en) begin
      out_item.last   <= last_b;
      out_item.dz     <= dz_b;
      out_item.is_div <= (op_b == OP_DIV) && !dz_b;
      out_item.neg    <= neg_b;
      out_item.etype  <= etype_b;
      out_item.res    <= (op_b == OP_MUL) ? (pp0 + {pp1 + pp2, 32'd0}) : res_b;
      out_item.rem    <= '0;
      out_item.quo    <= mag_a_b;
      out_item.dvs    <= mag_b_b;
    end
  end

endmodule
`default_nettype wire

/* hdl/tvsa_div_stage.sv */
// one restoring division step: one quotient bit per register stage
// depends on tvsa_pkg
`timescale 1ns / 1ps
`default_nettype none
module tvsa_div_stage (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_v,
  input  tvsa_pkg::tvsa_item_t      in_item,
  output logic                      out_v,
  output tvsa_pkg::tvsa_item_t      out_item
);
  import tvsa_pkg::*;

  logic [DATA_W:0] sh, diff;
  logic ge;
  tvsa_item_t nxt;

  always_comb begin
    sh      = {in_item.rem, in_item.quo[DATA_W-1]};
    diff    = sh - {1'b0, in_item.dvs};
    ge      = !diff[DATA_W];
    nxt     = in_item;
    nxt.rem = ge ? diff[DATA_W-1:0] : sh[DATA_W-1:0];
    nxt.quo = {in_item.quo[DATA_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
    if (en) begin
      out_item <= nxt;
    end
  end

endmodule
`default_nettype wire

/* hdl/typed_vector_scalar_alu_unit.sv */
// top level: config registers, front end, division chain and output stage
// depends on tvsa_pkg, tvsa_front, tvsa_div_stage
// pipeline stages: 3 front, 64 divide, 1 output register
// throughput: one beat per cycle; the whole pipeline holds while out_stall is high
// with a result waiting
// reset: synchronous, clears valid bits and sets element_type 2, operation add, scalar 0
`timescale 1ns / 1ps
`default_nettype none
module typed_vector_scalar_alu_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [tvsa_pkg::DATA_W-1:0] cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [tvsa_pkg::DATA_W-1:0] element_value,
  input  wire logic                        last_element,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [tvsa_pkg::DATA_W-1:0]      result_value,
  output logic                             divide_by_zero,
  output logic                             result_last
);
  import tvsa_pkg::*;

  logic [2:0] element_type;
  logic [1:0] operation;
  logic [DATA_W-1:0] scalar;
  logic en;
  logic [DIV_STEPS:0] v;
  tvsa_item_t item [DIV_STEPS+1];
  tvsa_item_t fin;
  logic [DATA_W-1:0] q;

  assign cfg_ready = 1'b1;
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_type <= 3'd2;
      operation    <= OP_ADD;
      scalar       <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ETYPE:  element_type <= cfg_data[2:0];
        CFG_OP:     operation    <= cfg_data[1:0];
        CFG_SCALAR: scalar       <= cfg_data;
        default:    ;
      endcase
    end
  end

  tvsa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (in_valid),
    .elem     (element_value),
    .last_in  (last_element),
    .etype    (element_type),
    .op       (operation),
    .scalar   (scalar),
    .out_v    (v[0]),
    .out_item (item[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    tvsa_div_stage u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_v     (v[i]),
      .in_item  (item[i]),
      .out_v    (v[i+1]),
      .out_item (item[i+1])
    );
  end

  always_comb begin
    fin = item[DIV_STEPS];
    q   = fin.neg ? (~fin.quo + 64'd1) : fin.quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v[DIV_STEPS];
    end
    if (en) begin
      result_value   <= (fin.is_div ? q : fin.res) & width_mask(fin.etype[1:0]);
      divide_by_zero <= fin.dz;
      result_last    <= fin.last;
    end
  end

endmodule
`default_nettype wire

/* tb/sv/tb_typed_vector_scalar_alu_unit.sv */
// testbench for typed_vector_scalar_alu_unit: element-wise vector-by-scalar alu
// depends on tvsa_pkg and the rtl under hdl; predicts each result and checks every beat
`timescale 1ns / 1ps
module tb_typed_vector_scalar_alu_unit;
  import tvsa_pkg::*;

  localparam int LATENCY = 68;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic [63:0] value;
    logic        dz;
    logic        last;
  } alu_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_ETYPE;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] element_value = '0;
  logic        last_element = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] result_value;
  logic        divide_by_zero;
  logic        result_last;

  logic [2:0]  cur_etype = 3'd2;
  op_t         cur_op = OP_ADD;
  logic [63:0] cur_scalar = '0;

  alu_result_t pending_results[$];
  int errors = 0;
  int idle_cycles = 0;
  int sink_wait = 0;
  bit no_gaps = 1'b0;

  typed_vector_scalar_alu_unit dut (.*);

  always #4 clk = ~clk;

  function automatic alu_result_t compute_element(logic [63:0] elem, logic last);
    alu_result_t r;
    logic [63:0] mask, a, b, sa, sb, ma, mb, q;
    int w;
    w = 8 << cur_etype[1:0];
    mask = (w == 64) ? '1 : ((64'd1 << w) - 1);
    a = elem & mask;
    b = cur_scalar & mask;
    r.dz = 1'b0;
    r.last = last;
    case (cur_op)
      OP_ADD: r.value = a + b;
      OP_SUB: r.value = a - b;
      OP_MUL: r.value = a * b;
      default: begin
        if (b == 0) begin
          r.value = a;
          r.dz = 1'b1;
        end else if (!cur_etype[2]) begin
          sa = (w < 64 && a[w-1]) ? (a | ~mask) : a;
          sb = (w < 64 && b[w-1]) ? (b | ~mask) : b;
          ma = sa[63] ? -sa : sa;
          mb = sb[63] ? -sb : sb;
          q = ma / mb;
          r.value = (sa[63] != sb[63]) ? -q : q;
        end else begin
          r.value = a / b;
        end
      end
    endcase
    r.value &= mask;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // skewed toward extremes of the current width
  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000 >> (64 - (8 << cur_etype[1:0]));
      3: return $urandom_range(0, 3);
      4: return -64'($urandom_range(1, 3));
      default: return rand64();
    endcase
  endfunction

  task automatic wait_cycles(int n);
    repeat (n) @(negedge clk);
  endtask

  task automatic send_element(logic [63:0] elem, logic last);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      wait_cycles(gap);
    end
    in_valid <= 1'b1;
    element_value <= elem;
    last_element <= last;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(compute_element(elem, last));
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ETYPE: cur_etype = data[2:0];
      CFG_OP: cur_op = op_t'(data[1:0]);
      CFG_SCALAR: cur_scalar = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    wait_cycles(LATENCY + 4);
  endtask

  task automatic configure(logic [2:0] et, op_t op, logic [63:0] sc);
    drain();
    write_reg(CFG_ETYPE, 64'(et));
    write_reg(CFG_OP, 64'(op));
    write_reg(CFG_SCALAR, sc);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    logic [63:0] minval;
    send_element(64'd5, 1'b0);
    for (int et = 0; et < 8; et++) begin
      minval = 64'h8000_0000_0000_0000 >> (64 - (8 << et[1:0]));
      configure(et[2:0], OP_DIV, '1);
      send_element(minval, 1'b0);
      send_element('1, 1'b1);
      configure(et[2:0], OP_DIV, 64'hffff_ffff_ffff_ff00);
      send_element(64'd77, 1'b0);
    end
    configure(3'd3, OP_ADD, '1);
    send_element('1, 1'b1);
    configure(3'd7, OP_SUB, '0);
    send_element('0, 1'b0);
    configure(3'd0, OP_MUL, 64'h7f);
    send_element(64'h80, 1'b1);
    drain();
    write_reg(CFG_NONE, '1);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_random(int n_items);
    int k;
    k = 0;
    while (k < n_items) begin
      configure(3'($urandom_range(0, 7)), op_t'($urandom_range(0, 3)),
                ($urandom_range(0, 5) == 0) ? 64'd0 : pick_value());
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(5, 60)) begin
        send_element(pick_value(), 1'($urandom_range(0, 1)));
        k++;
      end
      no_gaps = 1'b0;
    end
  endtask

  // sink holds off for a drawn number of cycles after each beat, unless no_gaps is set
  always @(negedge clk) begin
    if (no_gaps) begin
      sink_wait = 0;
      out_stall <= 1'b0;
    end else if (sink_wait > 0) begin
      sink_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    alu_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      sink_wait = $urandom_range(0, 14);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected beat value %h", $time, result_value);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (result_value !== exp_r.value) begin
          $display("%0t: result_value expected %h actual %h", $time, exp_r.value,
                   result_value);
          errors++;
        end
        if (divide_by_zero !== exp_r.dz) begin
          $display("%0t: divide_by_zero expected %b actual %b", $time, exp_r.dz,
                   divide_by_zero);
          errors++;
        end
        if (result_last !== exp_r.last) begin
          $display("%0t: result_last expected %b actual %b", $time, exp_r.last,
                   result_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(1100);
    drain();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
